@@ rtl/core/double_ended_queue_assert.svh @@
// Assertion macros for the double-ended queue RTL.
// Included by modules that check their own logic; needs clock and reset in scope.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define DQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/core/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// No dependencies; imported by dq_cell and double_ended_queue.
package dq_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   // request modes
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_LIST       = 3'd4;
   localparam logic [2:0] MODE_CLEAR      = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // cell operations
   typedef logic [2:0] dq_op_type;
   localparam dq_op_type OP_HOLD       = 3'd0;
   localparam dq_op_type OP_PUSH_FRONT = 3'd1;
   localparam dq_op_type OP_PUSH_BACK  = 3'd2;
   localparam dq_op_type OP_POP_FRONT  = 3'd3;
   localparam dq_op_type OP_ROTATE     = 3'd4;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      dq_op_type                op;
      logic [CNT_W-1:0]         occ;
      logic signed [DATA_W-1:0] value;
   } dq_ctrl_type;

endpackage

@@ rtl/core/dq_cell.sv @@
// One storage cell of the queue chain; exchanges data with both neighbors.
// Depends on dq_pkg for the control struct and widths.
module dq_cell
   import dq_pkg::*;
(
   input  logic                     clock,
   input  dq_ctrl_type              ctrl,
   input  logic [PTR_W-1:0]         cell_index,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic signed [DATA_W-1:0] head_data,
   output logic signed [DATA_W-1:0] data,
   output logic signed [DATA_W-1:0] tail_data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic [CNT_W-1:0]         index_ext;
   logic [CNT_W-1:0]         tail_pos;
   logic                     is_tail;

   assign index_ext = {{(CNT_W-PTR_W){1'b0}}, cell_index};
   assign tail_pos  = ctrl.occ - CNT_W'(1);
   assign is_tail   = (index_ext == tail_pos);

   // select the next content from the broadcast operation
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         OP_PUSH_FRONT: data_in = left_data;
         OP_PUSH_BACK: begin
            if (index_ext == ctrl.occ) data_in = ctrl.value;
         end
         OP_POP_FRONT:  data_in = right_data;
         OP_ROTATE: begin
            if (is_tail) data_in = head_data;
            else if (index_ext < tail_pos) data_in = right_data;
         end
         default:       data_in = data_ff;
      endcase
   end

   // hold the entry; contents are undefined until written
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign tail_data = is_tail ? data_ff : '0;

endmodule

@@ rtl/core/double_ended_queue.sv @@
// Channel   | Ports                                         | Direction
// ----------+-----------------------------------------------+----------
// request   | req_valid, req_stall, req_mode, req_value     | in
// response  | rsp_valid, rsp_stall, rsp_status, rsp_item,    | out
//           | rsp_last                                      |
//
// Push, pop and clear responses are registered and appear the cycle after acceptance.
// During a listing the chain rotates one place per cycle while the output is not stalled,
// and the head cell feeds the response register.
// Reset clears occupancy, the sequencer and the response valid; cell contents stay undefined.
// rsp_stall holds the response register and stalls the request side combinationally.
//
// Top level of the double-ended queue: sequencer, response register and cell chain.
// Depends on dq_pkg, dq_cell and double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module double_ended_queue
   import dq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic                     state_ff,  state_in;
   logic [CNT_W-1:0]         occ_ff,    occ_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     rsp_valid_ff,  rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_item_ff,   rsp_item_in;
   logic                     rsp_last_ff,   rsp_last_in;

   logic                     out_free;
   logic                     accept;
   logic                     is_empty;
   logic                     is_full;
   dq_ctrl_type              ctrl;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic signed [DATA_W-1:0] cell_tail [CAPACITY];
   logic signed [DATA_W-1:0] tail_value;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_LIST) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign is_empty  = (occ_ff == '0);
   assign is_full   = (occ_ff == FULL_COUNT);

   // collect the back entry; only the tail cell drives nonzero
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_value = tail_value | cell_tail[i];
      end
   end

   // sequence requests and listings, drive the cell chain
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl.op       = OP_HOLD;
      ctrl.occ      = occ_ff;
      ctrl.value    = req_value;

      if (state_ff == ST_LIST) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_item_in   = cell_data[0];
            rsp_last_in   = (remain_ff == CNT_W'(1));
            ctrl.op       = OP_ROTATE;
            remain_in     = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) state_in = ST_IDLE;
         end
      end else if (accept) begin
         rsp_last_in = 1'b1;
         unique case (req_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_item_in   = '0;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_item_in   = req_value;
                  occ_in        = occ_ff + CNT_W'(1);
                  ctrl.op       = (req_mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                : OP_PUSH_BACK;
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_item_in   = '0;
               end else begin
                  rsp_status_in = STATUS_OK;
                  occ_in        = occ_ff - CNT_W'(1);
                  if (req_mode == MODE_POP_FRONT) begin
                     rsp_item_in = cell_data[0];
                     ctrl.op     = OP_POP_FRONT;
                  end else begin
                     rsp_item_in = tail_value;
                  end
               end
            end
            MODE_LIST: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_item_in   = '0;
               end else begin
                  state_in  = ST_LIST;
                  remain_in = occ_ff;
               end
            end
            MODE_CLEAR: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_item_in   = '0;
               occ_in        = '0;
            end
            default: begin
               rsp_last_in = rsp_last_ff;
            end
         endcase
      end
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // chain of cells, front at index zero
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_inner_left
         assign left_data = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_inner_right
         assign right_data = cell_data[g+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (PTR_W'(g)),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[g]),
         .tail_data  (cell_tail[g])
      );
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_last   = rsp_last_ff;

   `DQ_ASSERT(a_occ_bound, occ_ff <= FULL_COUNT, "occupancy exceeds capacity")
   `DQ_ASSERT(a_list_remain, (state_ff == ST_LIST) |-> (remain_ff != '0 && remain_ff <= occ_ff),
      "listing count out of range")
   `DQ_ASSERT(a_push_responds,
      (accept && (req_mode == MODE_PUSH_BACK || req_mode == MODE_PUSH_FRONT)) |=> rsp_valid_ff,
      "push gave no response")
   `DQ_ASSERT(a_list_occ_stable, (state_ff == ST_LIST) |=> $stable(occ_ff),
      "occupancy changed during listing")

endmodule
